@@ src/bitmap_frame_allocator_macros.svh @@
// Assertion macros shared by the frame allocator RTL.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bfa_pkg.sv @@
// Types and constants of the bitmap frame allocator.
package bfa_pkg;

   localparam int PF_W      = 12;
   localparam int LIMIT_W   = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic REG_FRAME_LIMIT = 1'b0;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [1:0] STATUS_NOTHING   = 2'd1;
   localparam logic [1:0] STATUS_NO_FRAME  = 2'd2;
   localparam logic [1:0] STATUS_FREED     = 2'd3;

   typedef struct packed {
      logic            op;
      logic [PF_W-1:0] page_frame;
      logic            kernel_page;
      logic            map_writable;
   } req_type;

   typedef struct packed {
      logic [PF_W-1:0] frame_number;
      logic            present;
      logic            writable;
      logic            user_access;
      logic [1:0]      status;
   } rsp_type;

endpackage

@@ src/bfa_word_search.sv @@
// Lowest clear bit search over one bitmap word, limited to its lowest valid_cnt bits.
module bfa_word_search #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]               word,
   input  logic [$clog2(WORD_BITS+1)-1:0]     valid_cnt,
   output logic                               hit,
   output logic [$clog2(WORD_BITS)-1:0]       hit_idx,
   output logic [WORD_BITS-1:0]               hit_mask
);

   localparam int BIT_W = $clog2(WORD_BITS);

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      // scan downward so the lowest clear bit wins
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!word[b] && (b < int'(valid_cnt))) begin
            hit     = 1'b1;
            hit_idx = BIT_W'(b);
         end
      end
      hit_mask = hit ? (WORD_BITS'(1) << hit_idx) : '0;
   end

endmodule

@@ src/bitmap_frame_allocator.sv @@
// Bitmap frame allocator: allocation scan time is set by MAP_WORDS, one
// used-map word per cycle through the single memory read port, with
// MAP_WORDS = MAX_FRAMES/WORD_BITS rounded up. A free is a read-modify-write
// of one word; a request that changes nothing goes straight to delivery.
// One request is processed at a time; the next request is taken as soon
// as the result is registered, even while it waits on rsp_stall. After
// reset a clearing pass writes the map (frame 0 stays reserved) while
// req_stall is high; CSR writes are accepted at any time. frame_limit is
// capped at MAX_FRAMES.
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  bfa_pkg::req_type                  req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bfa_pkg::rsp_type                  rsp_data,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bfa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bfa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bfa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int PF_W      = bfa_pkg::PF_W;
   localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PTR_W     = $clog2(MAP_WORDS + 1);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(WORD_BITS + 1);
   localparam int SPAN      = MAP_WORDS * WORD_BITS;
   localparam int BASE_W    = $clog2(SPAN + 1);
   localparam int CMP_W     = (BASE_W > bfa_pkg::LIMIT_W) ? BASE_W : bfa_pkg::LIMIT_W;
   localparam int FRM_CMP_W = ((PF_W > BASE_W) ? PF_W : BASE_W) + 1;
   // frame -> word split by reciprocal multiply, one correction step
   localparam int DIV_SH    = PF_W;
   localparam int DIV_RECIP = (1 << DIV_SH) / WORD_BITS;
   localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
   localparam int PROD_W    = PF_W + RECIP_W;
   localparam int QEXT_W    = PF_W + ADDR_W;

   localparam logic [CMP_W-1:0]     MAX_FRAMES_C = CMP_W'(MAX_FRAMES);
   localparam logic [FRM_CMP_W-1:0] MAX_FRAMES_F = FRM_CMP_W'(MAX_FRAMES);
   localparam logic [CMP_W-1:0]     WORD_BITS_C  = CMP_W'(WORD_BITS);
   localparam logic [PF_W-1:0]      WORD_BITS_P  = PF_W'(WORD_BITS);
   localparam logic [RECIP_W-1:0]   RECIP_C      = RECIP_W'(DIV_RECIP);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR,
      S_DELIVER
   } state_type;

   // ---------------------------------------------------------------- CSR
   logic [bfa_pkg::LIMIT_W-1:0] limit_ff;
   logic                        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == bfa_pkg::REG_FRAME_LIMIT);
   assign csr_prdata = (csr_paddr[2] == bfa_pkg::REG_FRAME_LIMIT) ?
                       bfa_pkg::CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bfa_pkg::LIMIT_RESET;
      end else if (csr_wr) begin
         limit_ff <= csr_pwdata[bfa_pkg::LIMIT_W-1:0];
      end
   end

   // ------------------------------------------------------------ memory
   logic [WORD_BITS-1:0] used_map_ff [MAP_WORDS];
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_map_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= used_map_ff[mem_raddr];
      end
   end

   // ------------------------------------------------------------ control
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic [PTR_W-1:0]     issue_ptr_ff, issue_ptr_in;
   logic                 chk_pend_ff, chk_pend_in;
   logic [ADDR_W-1:0]    chk_ptr_ff, chk_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bfa_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   bfa_pkg::rsp_type     res_ff, res_in;
   bfa_pkg::req_type     req_ff, req_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [ADDR_W-1:0]    word_ptr_ff, word_ptr_in;
   logic [BIT_W-1:0]     bit_ptr_ff, bit_ptr_in;

   logic                 req_xfer;
   logic                 slot_free;
   logic [CMP_W-1:0]     lim_eff;
   logic [CMP_W-1:0]     chk_base;
   logic [CMP_W-1:0]     chk_rem;
   logic                 chk_over;
   logic [CNT_W-1:0]     valid_cnt;
   logic                 hit;
   logic [BIT_W-1:0]     hit_idx;
   logic [WORD_BITS-1:0] hit_mask;
   logic [CMP_W-1:0]     found_frame;
   logic [PF_W-1:0]      q_est;
   logic [PF_W-1:0]      r_est;
   logic [PF_W-1:0]      q_fix;
   logic [PF_W-1:0]      r_fix;
   logic [QEXT_W-1:0]    q_ext;
   logic                 pf_in_range;
   logic                 scan_done;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign lim_eff   = (CMP_W'(limit_ff) < MAX_FRAMES_C) ? CMP_W'(limit_ff) : MAX_FRAMES_C;
   assign chk_base  = CMP_W'(chk_ptr_ff) * WORD_BITS_C;
   assign chk_over  = (chk_base >= lim_eff);
   assign chk_rem   = lim_eff - chk_base;
   assign valid_cnt = (chk_rem >= WORD_BITS_C) ? CNT_W'(WORD_BITS) : chk_rem[CNT_W-1:0];
   assign found_frame = chk_base + CMP_W'(hit_idx);

   assign pf_in_range = (FRM_CMP_W'(req_data.page_frame) < MAX_FRAMES_F);

   // quotient estimate is exact or one low
   assign q_est = PF_W'(prod_ff >> DIV_SH);
   assign r_est = req_ff.page_frame - PF_W'(q_est * WORD_BITS_P);
   assign q_fix = (r_est >= WORD_BITS_P) ? q_est + PF_W'(1) : q_est;
   assign r_fix = (r_est >= WORD_BITS_P) ? r_est - WORD_BITS_P : r_est;
   assign q_ext = QEXT_W'(q_fix);

   assign scan_done = chk_pend_ff && (chk_over || hit);

   bfa_word_search #(
      .WORD_BITS (WORD_BITS)
   ) u_search (
      .word      (rd_word_ff),
      .valid_cnt (valid_cnt),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .hit_mask  (hit_mask)
   );

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      issue_ptr_in = issue_ptr_ff;
      chk_pend_in  = chk_pend_ff;
      chk_ptr_in   = chk_ptr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      req_in       = req_ff;
      prod_in      = prod_ff;
      word_ptr_in  = word_ptr_ff;
      bit_ptr_in   = bit_ptr_ff;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
            // frame 0 means "no frame" and stays reserved
            mem_wdata = (clr_ptr_ff == '0) ? WORD_BITS'(1) : '0;
            clr_ptr_in = clr_ptr_ff + ADDR_W'(1);
            if (clr_ptr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_xfer) begin
               req_in = req_data;
               res_in = '0;
               if (req_data.op == bfa_pkg::OP_ALLOC) begin
                  if (req_data.page_frame != '0) begin
                     res_in.frame_number = req_data.page_frame;
                     res_in.status       = bfa_pkg::STATUS_NOTHING;
                     state_in            = S_DELIVER;
                  end else begin
                     issue_ptr_in = '0;
                     chk_pend_in  = 1'b0;
                     state_in     = S_SCAN;
                  end
               end else begin
                  if (req_data.page_frame == '0) begin
                     res_in.status = bfa_pkg::STATUS_NOTHING;
                     state_in      = S_DELIVER;
                  end else if (!pf_in_range) begin
                     res_in.status = bfa_pkg::STATUS_FREED;
                     state_in      = S_DELIVER;
                  end else begin
                     prod_in  = PROD_W'(req_data.page_frame) * PROD_W'(RECIP_C);
                     state_in = S_FREE_RD;
                  end
               end
            end
         end

         S_SCAN: begin
            if (scan_done) begin
               chk_pend_in = 1'b0;
               state_in    = S_DELIVER;
               if (chk_over) begin
                  res_in.status = bfa_pkg::STATUS_NO_FRAME;
               end else begin
                  mem_we                = 1'b1;
                  mem_waddr             = chk_ptr_ff;
                  mem_wdata             = rd_word_ff | hit_mask;
                  res_in.frame_number   = found_frame[PF_W-1:0];
                  res_in.present        = 1'b1;
                  res_in.writable       = req_ff.map_writable;
                  res_in.user_access    = !req_ff.kernel_page;
                  res_in.status         = bfa_pkg::STATUS_ALLOCATED;
               end
            end else if (issue_ptr_ff < PTR_W'(MAP_WORDS)) begin
               // read the next word while the current one is checked
               mem_re       = 1'b1;
               mem_raddr    = issue_ptr_ff[ADDR_W-1:0];
               chk_pend_in  = 1'b1;
               chk_ptr_in   = issue_ptr_ff[ADDR_W-1:0];
               issue_ptr_in = issue_ptr_ff + PTR_W'(1);
            end else begin
               chk_pend_in = 1'b0;
               if (!chk_pend_ff) begin
                  res_in.status = bfa_pkg::STATUS_NO_FRAME;
                  state_in      = S_DELIVER;
               end
            end
         end

         S_FREE_RD: begin
            mem_re      = 1'b1;
            mem_raddr   = q_ext[ADDR_W-1:0];
            word_ptr_in = q_ext[ADDR_W-1:0];
            bit_ptr_in  = r_fix[BIT_W-1:0];
            state_in    = S_FREE_WR;
         end

         S_FREE_WR: begin
            mem_we        = 1'b1;
            mem_waddr     = word_ptr_ff;
            mem_wdata     = rd_word_ff & ~(WORD_BITS'(1) << bit_ptr_ff);
            res_in.status = bfa_pkg::STATUS_FREED;
            state_in      = S_DELIVER;
         end

         S_DELIVER: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         issue_ptr_ff <= '0;
         chk_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         issue_ptr_ff <= issue_ptr_in;
         chk_pend_ff  <= chk_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ptr_ff  <= chk_ptr_in;
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      req_ff      <= req_in;
      prod_ff     <= prod_in;
      word_ptr_ff <= word_ptr_in;
      bit_ptr_ff  <= bit_ptr_in;
   end

   // ---------------------------------------------------------- assertions
   `BFA_ASSERT_IMPLY(a_alloc_one_bit, clock, reset, mem_we && (state_ff == S_SCAN), $countones(mem_wdata ^ rd_word_ff) == 1, "allocation must set exactly one clear bit")
   `BFA_ASSERT_IMPLY(a_alloc_not_zero, clock, reset, mem_we && (state_ff == S_SCAN), found_frame != '0, "frame 0 must never be allocated")
   `BFA_ASSERT_NEXT(a_hold_result, clock, reset, (state_ff == S_DELIVER) && rsp_valid_ff && rsp_stall, (state_ff == S_DELIVER) && rsp_valid_ff, "pending result overwrote a stalled transfer")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the bitmap frame allocator: random and directed requests.
`timescale 1ns / 100ps

module tb_top;

   localparam int NUM_FRAMES = 4096;
   localparam logic [bfa_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {bfa_pkg::REG_FRAME_LIMIT, 2'b00};
   localparam int HOLD_START = 4000;
   localparam int HOLD_LEN = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   bfa_pkg::req_type req_data = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bfa_pkg::rsp_type rsp_data;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [bfa_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bfa_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bfa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // model of the allocator
   bit [NUM_FRAMES-1:0] frame_used;
   logic [bfa_pkg::LIMIT_W-1:0] frames_managed;

   bfa_pkg::req_type pending_reqs[$];
   bfa_pkg::rsp_type awaited_rsps[$];
   int unsigned n_queued = 0;
   int unsigned n_accepted = 0;
   int unsigned mismatches = 0;
   logic req_taken = 1'b0;
   bfa_pkg::rsp_type want_rsp;

   int burst_left = 0;
   int gap_left = 0;
   int rx_cycle = 0;
   int stretch_left = 0;
   int stall_mode = 0;

   bitmap_frame_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one request to the frame map and returns the page entry update.
   function automatic bfa_pkg::rsp_type serve_request(bfa_pkg::req_type r);
      bfa_pkg::rsp_type o;
      int unsigned lim;
      int unsigned f;
      o = '0;
      if (r.op == bfa_pkg::OP_ALLOC) begin
         if (r.page_frame != '0) begin
            o.frame_number = r.page_frame;
            o.status = bfa_pkg::STATUS_NOTHING;
         end else begin
            lim = (32'(frames_managed) > NUM_FRAMES) ? NUM_FRAMES : 32'(frames_managed);
            f = 0;
            while (f < lim && frame_used[f])
               f++;
            if (f < lim) begin
               frame_used[f] = 1'b1;
               o.frame_number = bfa_pkg::PF_W'(f);
               o.present = 1'b1;
               o.writable = r.map_writable;
               o.user_access = !r.kernel_page;
               o.status = bfa_pkg::STATUS_ALLOCATED;
            end else begin
               o.status = bfa_pkg::STATUS_NO_FRAME;
            end
         end
      end else if (r.page_frame == '0) begin
         o.status = bfa_pkg::STATUS_NOTHING;
      end else begin
         frame_used[r.page_frame] = 1'b0;
         o.status = bfa_pkg::STATUS_FREED;
      end
      return o;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // monitor: predict on request transfer, check on result transfer
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            awaited_rsps.push_back(serve_request(req_data));
            n_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsps.size() == 0) begin
               $error("result transfer with no request outstanding: %h", rsp_data);
               mismatches++;
            end else begin
               want_rsp = awaited_rsps.pop_front();
               check_field("frame_number", 32'(want_rsp.frame_number),
                           32'(rsp_data.frame_number));
               check_field("present", 32'(want_rsp.present), 32'(rsp_data.present));
               check_field("writable", 32'(want_rsp.writable), 32'(rsp_data.writable));
               check_field("user_access", 32'(want_rsp.user_access),
                           32'(rsp_data.user_access));
               check_field("status", 32'(want_rsp.status), 32'(rsp_data.status));
            end
         end
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern, with one long hold-off so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
            rsp_stall <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(8, 64);
               stall_mode = $urandom_range(0, 2);
            end
            stretch_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   task automatic queue_request(input bfa_pkg::req_type r);
      pending_reqs.push_back(r);
      n_queued++;
   endtask

   function automatic bfa_pkg::req_type random_request(input int unsigned window);
      bfa_pkg::req_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.kernel_page = 1'($urandom_range(0, 1));
      r.map_writable = 1'($urandom_range(0, 1));
      if (pick < 55) begin
         r.op = bfa_pkg::OP_ALLOC;
         r.page_frame = '0;
      end else if (pick < 63) begin
         r.op = bfa_pkg::OP_ALLOC;
         r.page_frame = bfa_pkg::PF_W'($urandom);
      end else if (pick < 93) begin
         r.op = bfa_pkg::OP_FREE;
         r.page_frame = bfa_pkg::PF_W'($urandom_range(1, window));
      end else begin
         r.op = bfa_pkg::OP_FREE;
         r.page_frame = bfa_pkg::PF_W'($urandom);
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (n_accepted != n_queued || awaited_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [bfa_pkg::LIMIT_W-1:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= bfa_pkg::CSR_DATA_W'(val);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      frames_managed = val;
   endtask

   task automatic check_frame_limit(input logic [bfa_pkg::LIMIT_W-1:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= LIMIT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("frame_limit", bfa_pkg::CSR_DATA_W'(val), csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [bfa_pkg::LIMIT_W-1:0] lim, input int count,
                            input int unsigned window);
      write_frame_limit(lim);
      check_frame_limit(lim);
      repeat (count) queue_request(random_request(window));
      wait_drained();
   endtask

   initial begin
      frame_used = '0;
      frame_used[0] = 1'b1;
      frames_managed = bfa_pkg::LIMIT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_frame_limit(bfa_pkg::LIMIT_RESET);

      // first allocations, every kernel/writable mix
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b0});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b0});
      // page already holds a frame
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'hFFF, 1'b0, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'hAAA, 1'b1, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'h555, 1'b0, 1'b0});
      // free with no frame, then real frees and reuse of the lowest hole
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'd0, 1'b1, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'd2, 1'b0, 1'b0});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'hFFF, 1'b0, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'd1, 1'b1, 1'b0});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'd3, 1'b1, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b1});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b0});
      queue_request(bfa_pkg::req_type'{bfa_pkg::OP_FREE, 12'h800, 1'b0, 1'b0});
      wait_drained();

      // zero limit and a limit covering only the reserved frame: no frame ever
      run_phase(13'd0, 20, 8);
      run_phase(13'd1, 20, 8);
      // limit above the map size is capped
      run_phase(13'h1FFF, 300, 300);
      run_phase(13'd37, 250, 40);
      run_phase(13'd300, 300, 300);
      run_phase(13'd64, 200, 70);
      run_phase(bfa_pkg::LIMIT_RESET, 210, 500);

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
